/* src/cnd_pkg.sv */
// Package: shared constants, state and command types for the cut normalize/dedup block.
package cnd_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int ROWN_W = 6;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd3;

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EGCD,
        S_RGCD,
        S_DECIDE,
        S_NRD,
        S_NDIV,
        S_NWAIT,
        S_RSDIV,
        S_RSWAIT,
        S_INFO_WR,
        S_CJ,
        S_CJW,
        S_CA,
        S_CAL,
        S_CB,
        S_CBC,
        S_ERD,
        S_EOUT
    } state_t;

    typedef enum logic [1:0] {
        RD_CUR_I,
        RD_OLD_I,
        RD_CUR_K
    } rd_sel_t;

    typedef struct packed {
        logic    clear;
        logic    take_elem;
        logic    latch_run;
        logic    gcd_rs;
        logic    latch_g;
        logic    end_row;
        logic    emit_special;
        logic    store_orig;
        logic    begin_cut;
        logic    div_elem;
        logic    norm_wb;
        logic    div_rs;
        logic    latch_rsn;
        logic    info_wr;
        logic    i_clr;
        logic    i_inc;
        logic    j_inc;
        logic    a_load;
        logic    k_step;
        logic    set_match;
        logic    emit_elem;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic last_in;
        logic full;
        logic too_long;
        logic is_orig;
        logic g_zero;
        logic out_free;
        logic i_last;
        logic k_last;
        logic j_end;
        logic info_eq;
        logic hit;
    } dp_stat_t;

endpackage

/* src/cnd_ifs.sv */
// Interfaces: input element channel and result channel.
interface cnd_in_if;
    import cnd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [IDX_W-1:0]         var_index;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] right_side;
    logic                     last_element;

    modport source (output valid, output command, output var_index, output coefficient,
                    output right_side, output last_element, input ready);
    modport sink (input valid, input command, input var_index, input coefficient,
                  input right_side, input last_element, output ready);
endinterface

interface cnd_out_if;
    import cnd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] norm_coefficient;
    logic [IDX_W-1:0]         norm_var_index;
    logic signed [DATA_W-1:0] norm_right_side;
    logic [DATA_W-1:0]        divisor;
    logic                     is_repeat;
    logic [ROWN_W-1:0]        match_row;
    logic [ROWN_W-1:0]        row_number;
    logic [STAT_W-1:0]        status;
    logic                     last_out;

    modport source (output valid, output norm_coefficient, output norm_var_index,
                    output norm_right_side, output divisor, output is_repeat,
                    output match_row, output row_number, output status,
                    output last_out, input ready);
    modport sink (input valid, input norm_coefficient, input norm_var_index,
                  input norm_right_side, input divisor, input is_repeat,
                  input match_row, input row_number, input status,
                  input last_out, output ready);
endinterface

/* src/cnd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cnd_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/cnd_gcd.sv */
// Iterative binary GCD unit, one step per cycle.
module cnd_gcd #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int KW = $clog2(W + 1);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  res_reg;
    logic [KW-1:0] k_reg;
    logic          busy_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (a_reg == '0 || b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            priority if (a_reg == '0)
            begin
                res_reg <= W'(b_reg << k_reg);
            end
            else if (b_reg == '0)
            begin
                res_reg <= W'(a_reg << k_reg);
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= a_reg - b_reg;
            end
            else
            begin
                b_reg <= b_reg - a_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

/* src/cnd_div.sv */
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module cnd_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] dvsr,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    q_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    d_reg;
    logic [W-1:0]    res_reg;
    logic            neg_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [W:0]      rem_sh;
    logic            ge;
    logic [W-1:0]    rem_next;
    logic [W-1:0]    q_next;

    assign rem_sh   = {rem_reg, q_reg[W-1]};
    assign ge       = rem_sh >= {1'b0, d_reg};
    assign rem_next = ge ? W'(rem_sh - {1'b0, d_reg}) : rem_sh[W-1:0];
    assign q_next   = {q_reg[W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[W-1];
            q_reg   <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            d_reg   <= dvsr;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNTW'(W - 1))
            begin
                res_reg <= neg_reg ? (~q_next + 1'b1) : q_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = res_reg;
endmodule

/* src/cnd_dp.sv */
// Datapath: row stores, GCD and divide units, counters, compare logic and result register.
module cnd_dp #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_ELEMS  = 32,
    parameter int COEF_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cnd_pkg::dp_cmd_t             cmd,
    output cnd_pkg::dp_stat_t            stat,
    input  logic [cnd_pkg::CFG_W-1:0]    orig_count,
    input  logic [cnd_pkg::IDX_W-1:0]    in_var_index,
    input  logic [cnd_pkg::DATA_W-1:0]   in_coefficient,
    input  logic [cnd_pkg::DATA_W-1:0]   in_right_side,
    input  logic                         in_last,
    cnd_out_if.source                    out_ch
);
    import cnd_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_ROWS + 1);
    localparam int SW     = $clog2(MAX_ELEMS);
    localparam int LW     = $clog2(MAX_ELEMS + 1);
    localparam int AW     = RW + SW;
    localparam int EW     = IDX_W + W;
    localparam int IW     = LW + W;
    localparam int EDEPTH = MAX_ROWS * (2 ** SW);

    function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    logic [CW-1:0]       row_cnt_reg;
    logic [LW-1:0]       fill_reg;
    logic [W-1:0]        run_reg;
    logic                tl_reg;
    logic [LW-1:0]       i_reg;
    logic [LW-1:0]       k_reg;
    logic [CW-1:0]       j_reg;
    logic                found_reg;
    logic                out_valid_reg;

    logic [W-1:0]        g_reg;
    logic signed [W-1:0] rs_reg;
    logic signed [W-1:0] rsn_reg;
    logic [LW-1:0]       n_reg;
    logic                last_reg;
    logic                zero_reg;
    logic                rep_reg;
    logic [RW-1:0]       match_reg;
    logic [EW-1:0]       a_reg;

    logic signed [DATA_W-1:0] o_coef_reg;
    logic [IDX_W-1:0]         o_idx_reg;
    logic signed [DATA_W-1:0] o_rs_reg;
    logic [DATA_W-1:0]        o_div_reg;
    logic                     o_rep_reg;
    logic [ROWN_W-1:0]        o_match_reg;
    logic [ROWN_W-1:0]        o_rown_reg;
    logic [STAT_W-1:0]        o_stat_reg;
    logic                     o_last_reg;

    logic [RW-1:0] r_idx;
    logic [W-1:0]  in_coef_w;
    logic          elem_ok;
    logic          full;
    logic          out_free;
    logic          i_last;
    logic          k_last;
    logic          hit;

    logic          e_we;
    logic [AW-1:0] e_waddr;
    logic [EW-1:0] e_wdata;
    logic [AW-1:0] e_raddr;
    logic [EW-1:0] e_rdata;
    logic          f_we;
    logic [IW-1:0] f_wdata;
    logic [IW-1:0] f_rdata;

    logic          gcd_start;
    logic [W-1:0]  gcd_a;
    logic [W-1:0]  gcd_b;
    logic          gcd_done;
    logic [W-1:0]  gcd_res;
    logic          div_start;
    logic [W-1:0]  div_n;
    logic          div_done;
    logic [W-1:0]  div_q;

    assign r_idx     = row_cnt_reg[RW-1:0];
    assign in_coef_w = in_coefficient[W-1:0];
    assign elem_ok   = fill_reg < LW'(MAX_ELEMS);
    assign full      = row_cnt_reg >= CW'(MAX_ROWS);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign i_last    = (i_reg + LW'(1)) == n_reg;
    assign k_last    = (k_reg + LW'(1)) == n_reg;
    assign hit       = found_reg || (e_rdata == a_reg);

    assign e_we    = (cmd.take_elem && elem_ok && !full) || cmd.norm_wb;
    assign e_waddr = cmd.norm_wb ? {r_idx, i_reg[SW-1:0]} : {r_idx, fill_reg[SW-1:0]};
    assign e_wdata = cmd.norm_wb ? {e_rdata[EW-1:W], div_q} : {in_var_index, in_coef_w};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CUR_I: e_raddr = {r_idx, i_reg[SW-1:0]};
            RD_OLD_I: e_raddr = {j_reg[RW-1:0], i_reg[SW-1:0]};
            RD_CUR_K: e_raddr = {r_idx, k_reg[SW-1:0]};
            default:  e_raddr = {r_idx, i_reg[SW-1:0]};
        endcase
    end

    assign f_we    = cmd.store_orig || cmd.info_wr;
    assign f_wdata = cmd.store_orig ? {fill_reg, rs_reg} : {n_reg, rsn_reg};

    cnd_ram #(.DW(EW), .DEPTH(EDEPTH)) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    cnd_ram #(.DW(IW), .DEPTH(MAX_ROWS)) u_info_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (r_idx),
        .wdata (f_wdata),
        .raddr (j_reg[RW-1:0]),
        .rdata (f_rdata)
    );

    assign gcd_start = cmd.take_elem || cmd.gcd_rs;
    assign gcd_a     = cmd.gcd_rs ? gcd_res : run_reg;
    assign gcd_b     = cmd.gcd_rs ? mag_f(rs_reg) : (elem_ok ? mag_f(in_coef_w) : '0);

    cnd_gcd #(.W(W)) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a      (gcd_a),
        .b      (gcd_b),
        .done   (gcd_done),
        .result (gcd_res)
    );

    assign div_start = cmd.div_elem || cmd.div_rs;
    assign div_n     = cmd.div_rs ? rs_reg : e_rdata[W-1:0];

    cnd_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .dvsr     (g_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            fill_reg      <= '0;
            run_reg       <= '0;
            tl_reg        <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                row_cnt_reg <= '0;
                fill_reg    <= '0;
                run_reg     <= '0;
                tl_reg      <= 1'b0;
            end
            if (cmd.take_elem)
            begin
                if (elem_ok)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    tl_reg <= 1'b1;
                end
            end
            if (cmd.latch_run)
            begin
                run_reg <= gcd_res;
            end
            if (cmd.end_row)
            begin
                fill_reg <= '0;
                run_reg  <= '0;
                tl_reg   <= 1'b0;
            end
            if (cmd.store_orig || (cmd.emit_elem && i_last))
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            if (cmd.begin_cut || cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.begin_cut)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.a_load)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.k_step)
            begin
                k_reg     <= k_reg + 1'b1;
                found_reg <= hit;
            end
            if (cmd.emit_special || cmd.emit_elem)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_elem)
        begin
            last_reg <= in_last;
            rs_reg   <= in_right_side[W-1:0];
        end
        if (cmd.latch_g)
        begin
            g_reg <= gcd_res;
        end
        if (cmd.end_row)
        begin
            n_reg <= fill_reg;
        end
        if (cmd.begin_cut)
        begin
            zero_reg  <= (g_reg == '0);
            rsn_reg   <= rs_reg;
            rep_reg   <= 1'b0;
            match_reg <= '0;
        end
        if (cmd.latch_rsn)
        begin
            rsn_reg <= div_q;
        end
        if (cmd.a_load)
        begin
            a_reg <= e_rdata;
        end
        if (cmd.set_match)
        begin
            rep_reg   <= 1'b1;
            match_reg <= j_reg[RW-1:0];
        end
        if (cmd.emit_special)
        begin
            o_coef_reg  <= '0;
            o_idx_reg   <= '0;
            o_rs_reg    <= '0;
            o_div_reg   <= '0;
            o_rep_reg   <= 1'b0;
            o_match_reg <= '0;
            o_rown_reg  <= full ? '0 : ROWN_W'(row_cnt_reg);
            o_stat_reg  <= full ? ST_FULL : ST_TRUNC;
            o_last_reg  <= 1'b1;
        end
        else if (cmd.emit_elem)
        begin
            o_coef_reg  <= DATA_W'($signed(e_rdata[W-1:0]));
            o_idx_reg   <= e_rdata[EW-1:W];
            o_rs_reg    <= DATA_W'(rsn_reg);
            o_div_reg   <= DATA_W'(g_reg);
            o_rep_reg   <= rep_reg;
            o_match_reg <= ROWN_W'(match_reg);
            o_rown_reg  <= ROWN_W'(row_cnt_reg);
            o_stat_reg  <= zero_reg ? ST_ZERO : ST_OK;
            o_last_reg  <= i_last;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.norm_coefficient = o_coef_reg;
    assign out_ch.norm_var_index   = o_idx_reg;
    assign out_ch.norm_right_side  = o_rs_reg;
    assign out_ch.divisor          = o_div_reg;
    assign out_ch.is_repeat        = o_rep_reg;
    assign out_ch.match_row        = o_match_reg;
    assign out_ch.row_number       = o_rown_reg;
    assign out_ch.status           = o_stat_reg;
    assign out_ch.last_out         = o_last_reg;

    assign stat.gcd_done = gcd_done;
    assign stat.div_done = div_done;
    assign stat.last_in  = last_reg;
    assign stat.full     = full;
    assign stat.too_long = tl_reg;
    assign stat.is_orig  = 32'(row_cnt_reg) < 32'(orig_count);
    assign stat.g_zero   = g_reg == '0;
    assign stat.out_free = out_free;
    assign stat.i_last   = i_last;
    assign stat.k_last   = k_last;
    assign stat.j_end    = j_reg == row_cnt_reg;
    assign stat.info_eq  = (f_rdata[IW-1:W] == n_reg) && (f_rdata[W-1:0] == rsn_reg);
    assign stat.hit      = hit;
endmodule

/* src/cnd_ctrl.sv */
// Controller: sequences element intake, GCD, normalization, compare and emission.
module cnd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_command,
    output logic               in_ready,
    input  cnd_pkg::dp_stat_t  stat,
    output cnd_pkg::dp_cmd_t   cmd
);
    import cnd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_command == CMD_ELEMENT)
                begin
                    state_next = S_EGCD;
                end
            end
            S_EGCD:
            begin
                if (stat.gcd_done)
                begin
                    state_next = stat.last_in ? S_RGCD : S_IDLE;
                end
            end
            S_RGCD:
            begin
                if (stat.gcd_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    priority if (stat.full || stat.too_long || stat.is_orig)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.g_zero)
                    begin
                        state_next = S_INFO_WR;
                    end
                    else
                    begin
                        state_next = S_NRD;
                    end
                end
            end
            S_NRD:    state_next = S_NDIV;
            S_NDIV:   state_next = S_NWAIT;
            S_NWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.i_last ? S_RSDIV : S_NRD;
                end
            end
            S_RSDIV:  state_next = S_RSWAIT;
            S_RSWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_INFO_WR;
                end
            end
            S_INFO_WR: state_next = S_CJ;
            S_CJ:      state_next = stat.j_end ? S_ERD : S_CJW;
            S_CJW:     state_next = stat.info_eq ? S_CA : S_CJ;
            S_CA:      state_next = S_CAL;
            S_CAL:     state_next = S_CB;
            S_CB:      state_next = S_CBC;
            S_CBC:
            begin
                priority if (!stat.k_last)
                begin
                    state_next = S_CB;
                end
                else if (!stat.hit)
                begin
                    state_next = S_CJ;
                end
                else if (stat.i_last)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_CA;
                end
            end
            S_ERD:     state_next = S_EOUT;
            S_EOUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.i_last ? S_IDLE : S_ERD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_CUR_I;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clear     = (in_command == CMD_CLEAR);
                    cmd.take_elem = (in_command == CMD_ELEMENT);
                end
            end
            S_EGCD:
            begin
                cmd.latch_run = stat.gcd_done;
                cmd.gcd_rs    = stat.gcd_done && stat.last_in;
            end
            S_RGCD:
            begin
                cmd.latch_g = stat.gcd_done;
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.end_row = 1'b1;
                    priority if (stat.full || stat.too_long)
                    begin
                        cmd.emit_special = 1'b1;
                    end
                    else if (stat.is_orig)
                    begin
                        cmd.store_orig = 1'b1;
                    end
                    else
                    begin
                        cmd.begin_cut = 1'b1;
                    end
                end
            end
            S_NRD:
            begin
                cmd.rd_sel = RD_CUR_I;
            end
            S_NDIV:
            begin
                cmd.div_elem = 1'b1;
            end
            S_NWAIT:
            begin
                cmd.norm_wb = stat.div_done;
                cmd.i_inc   = stat.div_done && !stat.i_last;
            end
            S_RSDIV:
            begin
                cmd.div_rs = 1'b1;
            end
            S_RSWAIT:
            begin
                cmd.latch_rsn = stat.div_done;
            end
            S_INFO_WR:
            begin
                cmd.info_wr = 1'b1;
            end
            S_CJ:
            begin
                cmd.i_clr = stat.j_end;
            end
            S_CJW:
            begin
                cmd.i_clr = stat.info_eq;
                cmd.j_inc = !stat.info_eq;
            end
            S_CA:
            begin
                cmd.rd_sel = RD_OLD_I;
            end
            S_CAL:
            begin
                cmd.rd_sel = RD_OLD_I;
                cmd.a_load = 1'b1;
            end
            S_CB:
            begin
                cmd.rd_sel = RD_CUR_K;
            end
            S_CBC:
            begin
                cmd.rd_sel = RD_CUR_K;
                cmd.k_step = 1'b1;
                if (stat.k_last)
                begin
                    cmd.j_inc     = !stat.hit;
                    cmd.set_match = stat.hit && stat.i_last;
                    cmd.i_clr     = stat.hit && stat.i_last;
                    cmd.i_inc     = stat.hit && !stat.i_last;
                end
            end
            S_ERD:
            begin
                cmd.rd_sel = RD_CUR_I;
            end
            S_EOUT:
            begin
                cmd.emit_elem = stat.out_free;
                cmd.i_inc     = stat.out_free && !stat.i_last;
            end
            default:
            begin
                cmd.rd_sel = RD_CUR_I;
            end
        endcase
    end
endmodule

/* src/cut_normalize_and_dedup_top.sv */
// Each element passes through the binary GCD unit. At row end a cut is normalized in the shared
// serial divider, then compared against the stored rows through one RAM read port, then emitted
// one result at a time. Originals are stored in the decide state that follows the row GCD, once
// the output register is free.
// Reset clears row count, fill count, running GCD and the output valid flag; stores
// need no clearing pass.
module cut_normalize_and_dedup_top #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_ELEMS  = 32,
    parameter int COEF_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cnd_pkg::CFG_W-1:0] cfg_wr_data,
    cnd_in_if.sink                    in_ch,
    cnd_out_if.source                 out_ch
);
    import cnd_pkg::*;

    logic [CFG_W-1:0] orig_count_reg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            orig_count_reg <= cfg_wr_data;
        end
    end

    cnd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    cnd_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_ELEMS  (MAX_ELEMS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .orig_count     (orig_count_reg),
        .in_var_index   (in_ch.var_index),
        .in_coefficient (in_ch.coefficient),
        .in_right_side  (in_ch.right_side),
        .in_last        (in_ch.last_element),
        .out_ch         (out_ch)
    );
endmodule
